// ===== sv/sql_array_literal_int_parser_defines.svh =====
// ---------------------------------------------------------------------------
// sql_array_literal_int_parser_defines: assertion macros for the array
// literal parser. Bodies are empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef SQL_ARRAY_LITERAL_INT_PARSER_DEFINES_SVH
`define SQL_ARRAY_LITERAL_INT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SALIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SALIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SALIP_ASSERT_IMP(lbl, ante, cons, msg)
`define SALIP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/salip_pkg.sv =====
// ---------------------------------------------------------------------------
// salip_pkg
// Types, character codes and helpers shared by the array literal parser.
// ---------------------------------------------------------------------------
package salip_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_VALUE    = 2'd0,
    CFG_ELEMENT_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_MANY  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CONV_SKIP   = 2'd0,
    CONV_SIGN   = 2'd1,
    CONV_DIGITS = 2'd2,
    CONV_DONE   = 2'd3
  } conv_e;

  typedef enum logic [1:0] {
    NM_NONE = 2'd0,
    NM_N    = 2'd1,
    NM_NU   = 2'd2,
    NM_NO   = 2'd3
  } null_e;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // error flag bit positions
  localparam int FLAG_MALFORMED = 0;
  localparam int FLAG_TOO_MANY  = 1;
  localparam int FLAG_TOO_LONG  = 2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_U      = 8'h55;

  localparam logic [63:0] MAG_MAX_POS = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MAG_MAX_NEG = {1'b1, 63'd0};
  localparam logic [63:0] MUL_BASE    = 64'd922337203685477580;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [63:0] value_out;
    logic [15:0]        position;
    logic               is_null;
    status_e            status;
    logic               end_of_run;
  } out_t;

  // one queued command: a value, a status, or both
  typedef struct packed {
    logic        emit_val;
    logic        emit_st;
    logic        is_null;
    logic        negative;
    logic [63:0] mag;
    logic [15:0] position;
    status_e     status;
  } cmd_t;

  // largest magnitude that still takes *10 + d without passing the limit
  function automatic logic [63:0] sat_thresh(input logic neg, input logic [3:0] d);
    logic [3:0] cut;
    cut = neg ? 4'd8 : 4'd7;
    return (d > cut) ? (MUL_BASE - 64'd1) : MUL_BASE;
  endfunction

endpackage

// ===== sv/sql_array_literal_int_parser.sv =====
// ---------------------------------------------------------------------------
// sql_array_literal_int_parser: streaming integer array literal parser
// Takes one byte per cycle while the queue is not full and converts it
// combinationally. Results pass a QUEUE_DEPTH-command queue that absorbs
// output stalls, then the output register. A last byte ending a token gives
// a value, then a status. Reset clears parse state and both registers.
// ---------------------------------------------------------------------------
`include "sql_array_literal_int_parser_defines.svh"

module sql_array_literal_int_parser #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int TOKEN_CHARS  = 24,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  salip_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output salip_pkg::out_t                    out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [salip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [63:0]                        cfg_wdata_i
);

  logic [63:0]      fill_value_q;
  logic [16:0]      element_count_q;

  logic             q_push, q_full, q_valid, q_pop;
  salip_pkg::cmd_t  q_wcmd, q_rcmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_value_q    <= '0;
      element_count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == salip_pkg::CFG_FILL_VALUE) begin
        fill_value_q <= cfg_wdata_i;
      end else if (cfg_index_i == salip_pkg::CFG_ELEMENT_COUNT) begin
        element_count_q <= cfg_wdata_i[16:0];
      end
    end
  end

  salip_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .TOKEN_CHARS  (TOKEN_CHARS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .element_count_i (element_count_q),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .cmd_o           (q_wcmd)
  );

  salip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wcmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_rcmd),
    .pop_i   (q_pop)
  );

  salip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_rcmd),
    .q_pop_o      (q_pop),
    .fill_value_i (fill_value_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  `SALIP_ASSERT_IMP(a_no_push_when_full, q_push, !q_full, "push into full queue")
  `SALIP_ASSERT_IMP(a_pop_only_when_valid, q_pop, q_valid, "pop from empty queue")
  `SALIP_ASSERT_IMP(a_value_result_clean, out_valid_o && (out_data_o.kind == salip_pkg::KIND_VALUE), (out_data_o.status == salip_pkg::ST_OK) && !out_data_o.end_of_run, "value result carries status")
  `SALIP_ASSERT_IMP(a_null_is_fill, out_valid_o && out_data_o.is_null, out_data_o.value_out == fill_value_q, "null result differs from fill value")

endmodule

// ===== sv/salip_front.sv =====
// ---------------------------------------------------------------------------
// salip_front
// Takes one byte a cycle while the queue is not full, tracks tokens and
// converts digits, and pushes value and status commands into the queue.
// ---------------------------------------------------------------------------
module salip_front #(
  parameter int MAX_ELEMENTS = 65536,
  parameter int TOKEN_CHARS  = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  salip_pkg::in_t   in_data_i,
  input  logic [16:0]      element_count_i,
  input  logic             q_full_i,
  output logic             push_o,
  output salip_pkg::cmd_t  cmd_o
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (IDX_W > 17) ? IDX_W : 17;
  localparam int TL_W  = $clog2(TOKEN_CHARS + 1);

  logic                 in_token_q, in_token_d;
  logic [63:0]          acc_q, acc_d;
  salip_pkg::conv_e     phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic [TL_W-1:0]      tlen_q, tlen_d;
  salip_pkg::null_e     nm_q, nm_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [2:0]           flags_q, flags_d;
  logic                 at_start_q, at_start_d;

  logic                 accept;
  logic [7:0]           c;
  logic                 digit, white, do_acc;
  logic [3:0]           dval;
  logic [CMP_W-1:0]     idx_ext, cnt_ext, max_ext, limit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign c          = in_data_i.char_in;
  assign digit      = (c >= salip_pkg::CH_ZERO) && (c <= salip_pkg::CH_NINE);
  assign white      = (c == salip_pkg::CH_SPACE) ||
                      ((c >= salip_pkg::CH_TAB) && (c <= salip_pkg::CH_CR));
  assign dval       = 4'(c - salip_pkg::CH_ZERO);

  assign idx_ext = CMP_W'(idx_q);
  assign cnt_ext = CMP_W'(element_count_i);
  assign max_ext = CMP_W'(MAX_ELEMENTS);
  assign limit   = (cnt_ext < max_ext) ? cnt_ext : max_ext;

  always_comb begin
    in_token_d = in_token_q;
    acc_d      = acc_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    tlen_d     = tlen_q;
    nm_d       = nm_q;
    idx_d      = idx_q;
    flags_d    = flags_q;
    at_start_d = at_start_q;
    do_acc     = 1'b0;
    push_o     = 1'b0;
    cmd_o      = '0;

    if (accept) begin
      if (at_start_q && (c != salip_pkg::CH_LBRACE)) begin
        flags_d[salip_pkg::FLAG_MALFORMED] = 1'b1;
      end
      at_start_d = 1'b0;

      if ((c == salip_pkg::CH_LBRACE) || (c == salip_pkg::CH_SPACE)) begin
        // skipped
      end else if ((c == salip_pkg::CH_COMMA) || (c == salip_pkg::CH_RBRACE)) begin
        if (in_token_q) begin
          if (idx_ext < limit) begin
            push_o         = 1'b1;
            cmd_o.emit_val = 1'b1;
            cmd_o.is_null  = (nm_q == salip_pkg::NM_NU);
            cmd_o.negative = neg_q;
            cmd_o.mag      = acc_q;
            cmd_o.position = 16'(idx_ext);
            idx_d          = IDX_W'(idx_ext + CMP_W'(1));
          end else begin
            flags_d[salip_pkg::FLAG_TOO_MANY] = 1'b1;
          end
          in_token_d = 1'b0;
          acc_d      = '0;
          phase_d    = salip_pkg::CONV_SKIP;
          neg_d      = 1'b0;
          tlen_d     = '0;
          nm_d       = salip_pkg::NM_NONE;
        end
      end else begin
        in_token_d = 1'b1;
        if (tlen_q >= TL_W'(TOKEN_CHARS)) begin
          flags_d[salip_pkg::FLAG_TOO_LONG] = 1'b1;
        end else begin
          if (tlen_q == '0) begin
            nm_d = (c == salip_pkg::CH_N) ? salip_pkg::NM_N : salip_pkg::NM_NO;
          end else if (tlen_q == TL_W'(1)) begin
            nm_d = ((nm_q == salip_pkg::NM_N) && (c == salip_pkg::CH_U)) ?
                   salip_pkg::NM_NU : salip_pkg::NM_NO;
          end
          tlen_d = tlen_q + TL_W'(1);
          unique case (phase_q)
            salip_pkg::CONV_SKIP: begin
              if (white) begin
                // leading whitespace
              end else if ((c == salip_pkg::CH_PLUS) || (c == salip_pkg::CH_MINUS)) begin
                neg_d   = (c == salip_pkg::CH_MINUS);
                phase_d = salip_pkg::CONV_SIGN;
              end else begin
                phase_d = digit ? salip_pkg::CONV_DIGITS : salip_pkg::CONV_DONE;
                do_acc  = digit;
              end
            end
            salip_pkg::CONV_SIGN: begin
              phase_d = digit ? salip_pkg::CONV_DIGITS : salip_pkg::CONV_DONE;
              do_acc  = digit;
            end
            salip_pkg::CONV_DIGITS: begin
              if (digit) begin
                do_acc = 1'b1;
              end else begin
                phase_d = salip_pkg::CONV_DONE;
              end
            end
            salip_pkg::CONV_DONE: begin
            end
            default: begin
            end
          endcase
          if (do_acc) begin
            if (acc_q > salip_pkg::sat_thresh(neg_q, dval)) begin
              acc_d = neg_q ? salip_pkg::MAG_MAX_NEG : salip_pkg::MAG_MAX_POS;
            end else begin
              acc_d = (acc_q << 3) + (acc_q << 1) + 64'(dval);
            end
          end
        end
      end

      if (in_data_i.last_char) begin
        if (c != salip_pkg::CH_RBRACE) begin
          flags_d[salip_pkg::FLAG_MALFORMED] = 1'b1;
        end
        push_o        = 1'b1;
        cmd_o.emit_st = 1'b1;
        priority if (flags_d[salip_pkg::FLAG_MALFORMED]) begin
          cmd_o.status = salip_pkg::ST_MALFORMED;
        end else if (flags_d[salip_pkg::FLAG_TOO_MANY]) begin
          cmd_o.status = salip_pkg::ST_TOO_MANY;
        end else if (flags_d[salip_pkg::FLAG_TOO_LONG]) begin
          cmd_o.status = salip_pkg::ST_TOO_LONG;
        end else begin
          cmd_o.status = salip_pkg::ST_OK;
        end
        // restart for the next literal
        in_token_d = 1'b0;
        acc_d      = '0;
        phase_d    = salip_pkg::CONV_SKIP;
        neg_d      = 1'b0;
        tlen_d     = '0;
        nm_d       = salip_pkg::NM_NONE;
        idx_d      = '0;
        flags_d    = '0;
        at_start_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      acc_q      <= '0;
      phase_q    <= salip_pkg::CONV_SKIP;
      neg_q      <= 1'b0;
      tlen_q     <= '0;
      nm_q       <= salip_pkg::NM_NONE;
      idx_q      <= '0;
      flags_q    <= '0;
      at_start_q <= 1'b1;
    end else begin
      in_token_q <= in_token_d;
      acc_q      <= acc_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      tlen_q     <= tlen_d;
      nm_q       <= nm_d;
      idx_q      <= idx_d;
      flags_q    <= flags_d;
      at_start_q <= at_start_d;
    end
  end

endmodule

// ===== sv/salip_queue.sv =====
// ---------------------------------------------------------------------------
// salip_queue
// Small command FIFO between the byte front end and the result back end.
// ---------------------------------------------------------------------------
module salip_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  salip_pkg::cmd_t  cmd_i,
  output logic             full_o,
  output logic             valid_o,
  output salip_pkg::cmd_t  cmd_o,
  input  logic             pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  salip_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/salip_back.sv =====
// ---------------------------------------------------------------------------
// salip_back
// Expands queued commands into value and status results and holds them in
// the output register until transferred.
// ---------------------------------------------------------------------------
module salip_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  salip_pkg::cmd_t  q_cmd_i,
  output logic             q_pop_o,
  input  logic [63:0]      fill_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output salip_pkg::out_t  out_data_o
);

  logic             out_valid_q, out_valid_d;
  salip_pkg::out_t  out_q, out_d;
  logic             val_done_q, val_done_d;
  logic             load_en;
  logic [63:0]      value;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_en     = !out_valid_q || out_ready_i;
  assign value       = q_cmd_i.is_null ? fill_value_i :
                       (q_cmd_i.negative ? (64'd0 - q_cmd_i.mag) : q_cmd_i.mag);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    val_done_d  = val_done_q;
    q_pop_o     = 1'b0;
    if (load_en) begin
      out_valid_d = q_valid_i;
      if (q_valid_i) begin
        out_d = '0;
        if (q_cmd_i.emit_val && !val_done_q) begin
          out_d.kind      = salip_pkg::KIND_VALUE;
          out_d.value_out = value;
          out_d.position  = q_cmd_i.position;
          out_d.is_null   = q_cmd_i.is_null;
          out_d.status    = salip_pkg::ST_OK;
          // keep the entry when its status still has to go out
          if (q_cmd_i.emit_st) begin
            val_done_d = 1'b1;
          end else begin
            q_pop_o = 1'b1;
          end
        end else begin
          out_d.kind       = salip_pkg::KIND_STATUS;
          out_d.status     = q_cmd_i.status;
          out_d.end_of_run = 1'b1;
          val_done_d       = 1'b0;
          q_pop_o          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      val_done_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      val_done_q  <= val_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
